### src/hcbd_pkg.sv
`default_nettype none
// Shared types, constants and helper functions for the chunked body decoder.
package hcbd_pkg;

   localparam int COUNT_WIDTH = 32;
   localparam int HEX_RADIX_BITS = 4;

   localparam logic [7:0] CHAR_LF = 8'h0A;
   localparam logic [7:0] CHAR_CR = 8'h0D;

   localparam logic [1:0] STATUS_BUSY  = 2'd0;
   localparam logic [1:0] STATUS_DONE  = 2'd1;
   localparam logic [1:0] STATUS_ERROR = 2'd2;

   typedef enum logic [7:0] {
      PH_SIZE_LEAD = 8'b0000_0001,
      PH_SIZE_HEX  = 8'b0000_0010,
      PH_SIZE_TAIL = 8'b0000_0100,
      PH_DATA      = 8'b0000_1000,
      PH_DATA_END  = 8'b0001_0000,
      PH_TRAILER   = 8'b0010_0000,
      PH_DONE      = 8'b0100_0000,
      PH_ERROR     = 8'b1000_0000
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       stream_end;
      logic       body_start;
   } req_type;

   typedef struct packed {
      logic [7:0] payload_byte;
      logic       payload_valid;
      logic [1:0] status;
   } rsp_type;

   typedef struct packed {
      phase_type              phase;
      logic [COUNT_WIDTH-1:0] bytes_left;
      logic                   digit_seen;
      logic                   line_has_content;
   } state_type;

   // Returns a valid flag above the four-bit value of a hex digit.
   function automatic logic [HEX_RADIX_BITS:0] hex_digit(input logic [7:0] c);
      logic [7:0] d;
      logic       ok;
      d  = 8'h00;
      ok = 1'b0;
      if (c inside {[8'h30:8'h39]}) begin
         d  = c - 8'h30;
         ok = 1'b1;
      end else if (c inside {[8'h61:8'h66]}) begin
         d  = c - 8'h57;
         ok = 1'b1;
      end else if (c inside {[8'h41:8'h46]}) begin
         d  = c - 8'h37;
         ok = 1'b1;
      end
      return {ok, d[HEX_RADIX_BITS-1:0]};
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return (c inside {8'h20, [8'h09:8'h0D]});
   endfunction

endpackage
`default_nettype wire

### src/http_chunked_body_decoder.sv
`default_nettype none
// Top level of the HTTP chunked body decoder: state registers and result buffer.
//
//  Channel   Direction  Ports                                  Contents
//  req       in         req_valid, req_ready, req_payload      body byte, end, new body
//  rsp       out        rsp_valid, rsp_ready, rsp_payload      data byte, flag, status
//
// Each request yields exactly one result, registered in the result buffer.
// A new request is taken in every cycle while the result buffer has room; the parse
// state is updated by a single pass of byte compares and a shift-or or decrement on
// the size counter. The two-entry result buffer holds one extra request during a stall.
// Synchronous reset returns the parser to the start of a size line.
module http_chunked_body_decoder (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_ready,
   input  wire hcbd_pkg::req_type req_payload,
   output logic                   rsp_valid,
   input  wire                    rsp_ready,
   output hcbd_pkg::rsp_type      rsp_payload
);

   hcbd_pkg::state_type state_ff, state_in, state_step;
   hcbd_pkg::rsp_type   step_result;
   logic                accept;

   assign accept = req_valid && req_ready;

   hcbd_step u_step (
      .state_cur (state_ff),
      .req       (req_payload),
      .state_nxt (state_step),
      .result    (step_result)
   );

   assign state_in = accept ? state_step : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase            <= hcbd_pkg::PH_SIZE_LEAD;
         state_ff.bytes_left       <= '0;
         state_ff.digit_seen       <= 1'b0;
         state_ff.line_has_content <= 1'b0;
      end else begin
         state_ff <= state_in;
      end
   end

   hcbd_outbuf u_outbuf (
      .clock       (clock),
      .reset       (reset),
      .load        (accept),
      .load_data   (step_result),
      .can_load    (req_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

`ifndef ASSERT_OFF
   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff.phase == hcbd_pkg::PH_DONE && !(accept && req_payload.body_start))
      |=> state_ff.phase == hcbd_pkg::PH_DONE)
      else $error("Completed body left its final state without a new body.");

   a_error_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff.phase == hcbd_pkg::PH_ERROR && !(accept && req_payload.body_start))
      |=> state_ff.phase == hcbd_pkg::PH_ERROR)
      else $error("Error state was left without a new body.");

   a_data_count_live: assert property (@(posedge clock) disable iff (reset)
      state_ff.phase == hcbd_pkg::PH_DATA |-> state_ff.bytes_left != '0)
      else $error("Data phase entered with no bytes left to pass.");
`endif

endmodule
`default_nettype wire

### src/hcbd_step.sv
`default_nettype none
// Next-state and result logic for one request of the chunked body decoder.
module hcbd_step (
   input  wire hcbd_pkg::state_type state_cur,
   input  wire hcbd_pkg::req_type   req,
   output hcbd_pkg::state_type      state_nxt,
   output hcbd_pkg::rsp_type        result
);

   hcbd_pkg::state_type                        st;
   logic [hcbd_pkg::HEX_RADIX_BITS:0]          hex;
   logic                                       overflow;
   logic [hcbd_pkg::COUNT_WIDTH-1:0]           dec;

   always_comb begin
      if (req.body_start) begin
         st.phase            = hcbd_pkg::PH_SIZE_LEAD;
         st.bytes_left       = '0;
         st.digit_seen       = 1'b0;
         st.line_has_content = 1'b0;
      end else begin
         st = state_cur;
      end
   end

   assign hex = hcbd_pkg::hex_digit(req.data_byte);
   assign overflow = (st.bytes_left[hcbd_pkg::COUNT_WIDTH-1 -: hcbd_pkg::HEX_RADIX_BITS] != '0);
   assign dec = st.bytes_left - {{(hcbd_pkg::COUNT_WIDTH-1){1'b0}}, 1'b1};

   always_comb begin
      state_nxt            = st;
      result.payload_byte  = 8'h00;
      result.payload_valid = 1'b0;
      if (req.stream_end) begin
         case (st.phase)
            hcbd_pkg::PH_SIZE_LEAD, hcbd_pkg::PH_SIZE_HEX, hcbd_pkg::PH_SIZE_TAIL: begin
               state_nxt.phase = (st.digit_seen && st.bytes_left == '0) ?
                                 hcbd_pkg::PH_DONE : hcbd_pkg::PH_ERROR;
            end
            hcbd_pkg::PH_TRAILER: state_nxt.phase = hcbd_pkg::PH_DONE;
            hcbd_pkg::PH_DONE, hcbd_pkg::PH_ERROR: state_nxt.phase = st.phase;
            default: state_nxt.phase = hcbd_pkg::PH_ERROR;
         endcase
      end else begin
         case (st.phase)
            hcbd_pkg::PH_SIZE_LEAD, hcbd_pkg::PH_SIZE_HEX, hcbd_pkg::PH_SIZE_TAIL: begin
               if (req.data_byte == hcbd_pkg::CHAR_LF) begin
                  if (!st.digit_seen) begin
                     state_nxt.phase = hcbd_pkg::PH_ERROR;
                  end else if (st.bytes_left == '0) begin
                     state_nxt.phase            = hcbd_pkg::PH_TRAILER;
                     state_nxt.line_has_content = 1'b0;
                  end else begin
                     state_nxt.phase = hcbd_pkg::PH_DATA;
                  end
               end else if (st.phase == hcbd_pkg::PH_SIZE_TAIL) begin
                  state_nxt.phase = st.phase;
               end else if (!hex[hcbd_pkg::HEX_RADIX_BITS]) begin
                  if (!(st.phase == hcbd_pkg::PH_SIZE_LEAD &&
                        hcbd_pkg::is_space(req.data_byte))) begin
                     state_nxt.phase = hcbd_pkg::PH_SIZE_TAIL;
                  end
               end else if (overflow) begin
                  state_nxt.phase = hcbd_pkg::PH_ERROR;
               end else begin
                  state_nxt.bytes_left =
                     {st.bytes_left[hcbd_pkg::COUNT_WIDTH-hcbd_pkg::HEX_RADIX_BITS-1:0],
                      hex[hcbd_pkg::HEX_RADIX_BITS-1:0]};
                  state_nxt.digit_seen = 1'b1;
                  state_nxt.phase      = hcbd_pkg::PH_SIZE_HEX;
               end
            end
            hcbd_pkg::PH_DATA: begin
               result.payload_byte  = req.data_byte;
               result.payload_valid = 1'b1;
               state_nxt.bytes_left = dec;
               if (dec == '0) begin
                  state_nxt.phase            = hcbd_pkg::PH_DATA_END;
                  state_nxt.line_has_content = 1'b0;
               end
            end
            hcbd_pkg::PH_DATA_END: begin
               if (req.data_byte == hcbd_pkg::CHAR_LF) begin
                  if (st.line_has_content) begin
                     state_nxt.phase = hcbd_pkg::PH_ERROR;
                  end else begin
                     state_nxt.phase            = hcbd_pkg::PH_SIZE_LEAD;
                     state_nxt.bytes_left       = '0;
                     state_nxt.digit_seen       = 1'b0;
                     state_nxt.line_has_content = 1'b0;
                  end
               end else if (req.data_byte != hcbd_pkg::CHAR_CR) begin
                  state_nxt.line_has_content = 1'b1;
               end
            end
            hcbd_pkg::PH_TRAILER: begin
               if (req.data_byte == hcbd_pkg::CHAR_LF) begin
                  if (!st.line_has_content) begin
                     state_nxt.phase = hcbd_pkg::PH_DONE;
                  end
                  state_nxt.line_has_content = 1'b0;
               end else if (req.data_byte != hcbd_pkg::CHAR_CR) begin
                  state_nxt.line_has_content = 1'b1;
               end
            end
            hcbd_pkg::PH_DONE, hcbd_pkg::PH_ERROR: state_nxt.phase = st.phase;
            default: state_nxt.phase = hcbd_pkg::PH_ERROR;
         endcase
      end
      case (state_nxt.phase)
         hcbd_pkg::PH_DONE:  result.status = hcbd_pkg::STATUS_DONE;
         hcbd_pkg::PH_ERROR: result.status = hcbd_pkg::STATUS_ERROR;
         default:            result.status = hcbd_pkg::STATUS_BUSY;
      endcase
   end

endmodule
`default_nettype wire

### src/hcbd_outbuf.sv
`default_nettype none
// Result register with a skid stage for the chunked body decoder.
module hcbd_outbuf (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    load,
   input  wire hcbd_pkg::rsp_type load_data,
   output logic                   can_load,
   output logic                   rsp_valid,
   input  wire                    rsp_ready,
   output hcbd_pkg::rsp_type      rsp_payload
);

   logic              out_valid_ff, out_valid_in;
   hcbd_pkg::rsp_type out_data_ff, out_data_in;
   logic              skid_valid_ff, skid_valid_in;
   hcbd_pkg::rsp_type skid_data_ff, skid_data_in;
   logic              pop;

   assign pop      = out_valid_ff && rsp_ready;
   assign can_load = !skid_valid_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = load;
            out_data_in  = load_data;
         end
      end else if (load) begin
         skid_valid_in = 1'b1;
         skid_data_in  = load_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_data_ff;

`ifndef ASSERT_OFF
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("Skid stage holds a request while the result register is empty.");

   a_stall_fills_skid: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_ready && load) |=> skid_valid_ff)
      else $error("A request loaded during a stall was not kept in the skid stage.");

   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      (pop && skid_valid_ff) |=> (out_valid_ff && !skid_valid_ff))
      else $error("Skid stage did not move into the result register.");
`endif

endmodule
`default_nettype wire
